>>> src/sbs2d_pkg.sv
package sbs2d_pkg;

    localparam int MAX_RADIUS_X = 8;
    localparam int MAX_RADIUS_Y = 8;
    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 1024;
    localparam int PIXEL_BITS   = 16;

    localparam int PIX_W      = 16;
    localparam int HSUM_W     = 21;
    localparam int BOX_W      = 25;
    localparam int RADIUS_W   = 4;
    localparam int DIM_W      = 11;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 4;

    localparam int RING_DEPTH = 2 * MAX_RADIUS_X + 1;
    localparam int SLOT_DEPTH = 2 * MAX_RADIUS_Y + 1;
    localparam int TAP_W      = $clog2(RING_DEPTH);
    localparam int SLOT_W     = $clog2(SLOT_DEPTH);
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int LINE_DEPTH = SLOT_DEPTH * MAX_WIDTH;
    localparam int LINE_AW    = SLOT_W + COL_W;

    typedef enum logic [1:0] {
        REG_RADIUS_X = 2'd0,
        REG_RADIUS_Y = 2'd1,
        REG_WIDTH    = 2'd2,
        REG_HEIGHT   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [RADIUS_W-1:0] rx;
        logic [RADIUS_W-1:0] ry;
        logic [TAP_W-1:0]    nx_m1;
        logic [SLOT_W-1:0]   ny_m1;
        logic [COL_W-1:0]    w_m1;
        logic [ROW_W-1:0]    h_m1;
        logic                restart;
    } cfg_t;

    typedef struct packed {
        logic [HSUM_W-1:0] hsum;
        logic [COL_W-1:0]  x;
        logic [SLOT_W-1:0] slot;
        logic [ROW_W-1:0]  y;
        logic              first_row;
        logic              use_old;
        logic              emit;
        logic              last;
    } item_t;

endpackage

>>> src/sbs2d_cfg.sv
module sbs2d_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sbs2d_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [sbs2d_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [sbs2d_pkg::CFG_DATA_W-1:0] prdata,
    output logic                             pready,
    output sbs2d_pkg::cfg_t                  cfg
);

    logic [sbs2d_pkg::RADIUS_W-1:0] radius_x_reg, radius_y_reg;
    logic [sbs2d_pkg::DIM_W-1:0]    width_reg, height_reg;
    logic [sbs2d_pkg::RADIUS_W-1:0] rx_eff, ry_eff;
    logic                           wr_en;
    sbs2d_pkg::reg_idx_t            idx;

    assign pready = 1'b1;
    assign idx    = sbs2d_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_x_reg <= sbs2d_pkg::RADIUS_W'(1);
            radius_y_reg <= sbs2d_pkg::RADIUS_W'(1);
            width_reg    <= sbs2d_pkg::DIM_W'(sbs2d_pkg::MAX_WIDTH);
            height_reg   <= sbs2d_pkg::DIM_W'(sbs2d_pkg::MAX_HEIGHT);
        end else if (wr_en) begin
            case (idx)
                sbs2d_pkg::REG_RADIUS_X: radius_x_reg <= pwdata[sbs2d_pkg::RADIUS_W-1:0];
                sbs2d_pkg::REG_RADIUS_Y: radius_y_reg <= pwdata[sbs2d_pkg::RADIUS_W-1:0];
                sbs2d_pkg::REG_WIDTH:    width_reg    <= pwdata[sbs2d_pkg::DIM_W-1:0];
                sbs2d_pkg::REG_HEIGHT:   height_reg   <= pwdata[sbs2d_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            sbs2d_pkg::REG_RADIUS_X: prdata = sbs2d_pkg::CFG_DATA_W'(radius_x_reg);
            sbs2d_pkg::REG_RADIUS_Y: prdata = sbs2d_pkg::CFG_DATA_W'(radius_y_reg);
            sbs2d_pkg::REG_WIDTH:    prdata = sbs2d_pkg::CFG_DATA_W'(width_reg);
            sbs2d_pkg::REG_HEIGHT:   prdata = sbs2d_pkg::CFG_DATA_W'(height_reg);
            default:                 prdata = '0;
        endcase
    end

    assign rx_eff = (radius_x_reg > sbs2d_pkg::RADIUS_W'(sbs2d_pkg::MAX_RADIUS_X))
                  ? sbs2d_pkg::RADIUS_W'(sbs2d_pkg::MAX_RADIUS_X) : radius_x_reg;
    assign ry_eff = (radius_y_reg > sbs2d_pkg::RADIUS_W'(sbs2d_pkg::MAX_RADIUS_Y))
                  ? sbs2d_pkg::RADIUS_W'(sbs2d_pkg::MAX_RADIUS_Y) : radius_y_reg;

    always_comb begin
        cfg.rx      = rx_eff;
        cfg.ry      = ry_eff;
        cfg.nx_m1   = sbs2d_pkg::TAP_W'({rx_eff, 1'b0});
        cfg.ny_m1   = sbs2d_pkg::SLOT_W'({ry_eff, 1'b0});
        cfg.restart = wr_en;
        if (width_reg == '0) begin
            cfg.w_m1 = '0;
        end else if (width_reg > sbs2d_pkg::DIM_W'(sbs2d_pkg::MAX_WIDTH)) begin
            cfg.w_m1 = sbs2d_pkg::COL_W'(sbs2d_pkg::MAX_WIDTH - 1);
        end else begin
            cfg.w_m1 = sbs2d_pkg::COL_W'(width_reg - sbs2d_pkg::DIM_W'(1));
        end
        if (height_reg == '0) begin
            cfg.h_m1 = '0;
        end else if (height_reg > sbs2d_pkg::DIM_W'(sbs2d_pkg::MAX_HEIGHT)) begin
            cfg.h_m1 = sbs2d_pkg::ROW_W'(sbs2d_pkg::MAX_HEIGHT - 1);
        end else begin
            cfg.h_m1 = sbs2d_pkg::ROW_W'(height_reg - sbs2d_pkg::DIM_W'(1));
        end
    end

endmodule

>>> src/sbs2d_row.sv
module sbs2d_row (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  sbs2d_pkg::cfg_t             cfg,
    input  logic                        accept,
    input  logic [sbs2d_pkg::PIX_W-1:0] pixel,
    output sbs2d_pkg::item_t            item,
    output logic                        col_upd
);

    logic [sbs2d_pkg::COL_W-1:0]  col_reg, col_next;
    logic [sbs2d_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [sbs2d_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic [sbs2d_pkg::HSUM_W-1:0] rsum_reg, rsum_next;
    logic [sbs2d_pkg::PIX_W-1:0]  dly_reg [sbs2d_pkg::RING_DEPTH];
    logic [sbs2d_pkg::PIX_W-1:0]  px, tap;
    logic [sbs2d_pkg::HSUM_W-1:0] base, sub;
    logic                         row_end;

    assign px  = pixel & sbs2d_pkg::PIX_W'((1 << sbs2d_pkg::PIXEL_BITS) - 1);
    assign tap = dly_reg[cfg.nx_m1];

    assign base      = (col_reg == '0) ? '0 : rsum_reg;
    assign sub       = (sbs2d_pkg::COL_W'(cfg.nx_m1) < col_reg)
                     ? sbs2d_pkg::HSUM_W'(tap) : '0;
    assign rsum_next = base - sub + sbs2d_pkg::HSUM_W'(px);

    assign col_upd = col_reg >= sbs2d_pkg::COL_W'(cfg.nx_m1);
    assign row_end = col_reg == cfg.w_m1;

    always_comb begin
        item.hsum      = rsum_next;
        item.x         = col_reg - sbs2d_pkg::COL_W'(cfg.rx);
        item.slot      = slot_reg;
        item.y         = row_reg - sbs2d_pkg::ROW_W'(cfg.ry);
        item.first_row = row_reg == '0;
        item.use_old   = row_reg > sbs2d_pkg::ROW_W'(cfg.ny_m1);
        item.emit      = row_reg >= sbs2d_pkg::ROW_W'(cfg.ny_m1);
        item.last      = row_end && (row_reg == cfg.h_m1);
    end

    always_comb begin
        col_next  = col_reg + sbs2d_pkg::COL_W'(1);
        row_next  = row_reg;
        slot_next = slot_reg;
        if (row_end) begin
            col_next = '0;
            if (row_reg == cfg.h_m1) begin
                row_next  = '0;
                slot_next = '0;
            end else begin
                row_next  = row_reg + sbs2d_pkg::ROW_W'(1);
                slot_next = (slot_reg == cfg.ny_m1) ? '0 : slot_reg + sbs2d_pkg::SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg.restart) begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
            rsum_reg <= '0;
        end else if (accept) begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
            rsum_reg <= rsum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            dly_reg[0] <= px;
            for (int i = 1; i < sbs2d_pkg::RING_DEPTH; i++) begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

endmodule

>>> src/sbs2d_col.sv
module sbs2d_col (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  sbs2d_pkg::item_t            item,
    input  logic                        load,
    output logic                        ready,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [sbs2d_pkg::BOX_W-1:0] out_sum,
    output logic [sbs2d_pkg::COL_W-1:0] out_x,
    output logic [sbs2d_pkg::ROW_W-1:0] out_y,
    output logic                        out_last
);

    logic [sbs2d_pkg::BOX_W-1:0]   col_mem  [sbs2d_pkg::MAX_WIDTH];
    logic [sbs2d_pkg::HSUM_W-1:0]  line_mem [sbs2d_pkg::LINE_DEPTH];

    logic                          s1_valid_reg;
    sbs2d_pkg::item_t              s1_reg;
    logic [sbs2d_pkg::BOX_W-1:0]   col_q_reg, col_byp_reg;
    logic [sbs2d_pkg::HSUM_W-1:0]  line_q_reg, line_byp_reg;
    logic                          col_hit_reg, line_hit_reg;
    logic                          out_valid_reg;
    logic [sbs2d_pkg::BOX_W-1:0]   out_sum_reg;
    logic [sbs2d_pkg::COL_W-1:0]   out_x_reg;
    logic [sbs2d_pkg::ROW_W-1:0]   out_y_reg;
    logic                          out_last_reg;

    logic [sbs2d_pkg::LINE_AW-1:0] rd_addr, wr_addr;
    logic [sbs2d_pkg::BOX_W-1:0]   col_old, col_base, cs;
    logic [sbs2d_pkg::HSUM_W-1:0]  line_old;
    logic [sbs2d_pkg::BOX_W-1:0]   line_sub;
    logic                          s1_adv;

    assign rd_addr = {item.slot, item.x};
    assign wr_addr = {s1_reg.slot, s1_reg.x};

    assign s1_adv = s1_valid_reg && (!s1_reg.emit || !out_valid_reg || out_ready);
    assign ready  = !s1_valid_reg || s1_adv;

    // A write in the same cycle as the read is not seen by the memory read port.
    assign col_old  = col_hit_reg ? col_byp_reg : col_q_reg;
    assign line_old = line_hit_reg ? line_byp_reg : line_q_reg;
    assign col_base = s1_reg.first_row ? '0 : col_old;
    assign line_sub = s1_reg.use_old ? sbs2d_pkg::BOX_W'(line_old) : '0;
    assign cs       = col_base - line_sub + sbs2d_pkg::BOX_W'(s1_reg.hsum);

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            col_mem[s1_reg.x] <= cs;
        end
        if (load) begin
            col_q_reg <= col_mem[item.x];
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            line_mem[wr_addr] <= s1_reg.hsum;
        end
        if (load) begin
            line_q_reg <= line_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            s1_reg       <= item;
            col_hit_reg  <= s1_adv && (s1_reg.x == item.x);
            col_byp_reg  <= cs;
            line_hit_reg <= s1_adv && (wr_addr == rd_addr);
            line_byp_reg <= s1_reg.hsum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (load) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s1_adv && s1_reg.emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && s1_reg.emit) begin
            out_sum_reg  <= cs;
            out_x_reg    <= s1_reg.x;
            out_y_reg    <= s1_reg.y;
            out_last_reg <= s1_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_sum   = out_sum_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_last  = out_last_reg;

endmodule

>>> src/separable_box_sum_2d.sv
// Channel   Dir  Handshake                 Payload
// s_        in   s_tvalid / s_tready       s_tdata: pixel
// m_        out  m_tvalid / m_tready       m_tdata: box_sum, out_x, out_y; m_tlast: frame_last
// apb       in   psel, penable, pready     radius_x, radius_y, image_width, image_height
//
// One pixel is accepted per clock while s_tready is high; a result passes through the stage-one and output registers.
// The column-sum and line-store memories are read at acceptance and written back when
// the item leaves the first stage, with a one-entry bypass for back-to-back hits on the same entry.
// Every stored entry is written in the current frame before it is read, so reset
// needs no clearing pass and the block accepts pixels right after reset.
// A stalled result holds its register; s_tready drops only while a result waits there.
module separable_box_sum_2d (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [15:0]                      s_tdata,  // [15:0] pixel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [47:0]                      m_tdata,  // [24:0] box_sum, [34:25] out_x,
                                                       // [44:35] out_y, [47:45] zero
    output logic                             m_tlast,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sbs2d_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [sbs2d_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [sbs2d_pkg::CFG_DATA_W-1:0] prdata,
    output logic                             pready
);

    sbs2d_pkg::cfg_t             cfg;
    sbs2d_pkg::item_t            item;
    logic                        col_upd, col_ready, accept;
    logic [sbs2d_pkg::BOX_W-1:0] box_sum;
    logic [sbs2d_pkg::COL_W-1:0] out_x;
    logic [sbs2d_pkg::ROW_W-1:0] out_y;

    assign s_tready = col_ready;
    assign accept   = s_tvalid & s_tready;

    sbs2d_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sbs2d_row u_row (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .accept  (accept),
        .pixel   (s_tdata),
        .item    (item),
        .col_upd (col_upd)
    );

    sbs2d_col u_col (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item      (item),
        .load      (accept & col_upd),
        .ready     (col_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_sum   (box_sum),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_last  (m_tlast)
    );

    assign m_tdata = {3'b000, out_y, out_x, box_sum};

`ifndef SYNTH
    a_ready_when_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while the result register is empty");

    a_out_x_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_x + sbs2d_pkg::COL_W'(cfg.rx) <= cfg.w_m1))
        else $error("result column lies outside the full-window range");

    a_last_at_row_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> (out_x + sbs2d_pkg::COL_W'(cfg.rx) == cfg.w_m1))
        else $error("frame end flagged away from the last column");
`endif

endmodule
